>>> sv/triangle_normal_tangent_assert.svh
// Assertion helpers for the triangle normal and tangent block.
`ifndef TRIANGLE_NORMAL_TANGENT_ASSERT_SVH
`define TRIANGLE_NORMAL_TANGENT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TNT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TNT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tnt_pkg.sv
`default_nettype none

package tnt_pkg;

    // Magnitudes are block-aligned so the largest lies in [2^29, 2^30)
    localparam int ALIGN_BITS    = 30;
    // Sum of three squares of aligned magnitudes
    localparam int SUM_BITS      = 2 * ALIGN_BITS + 2;
    // Working width of the square root remainder and root
    localparam int ROOT_REM_BITS = SUM_BITS + 2;
    // One root bit per step, starting at 2^SUM_BITS
    localparam int ROOT_STEPS    = SUM_BITS / 2 + 1;
    localparam int ROOT_BITS     = ALIGN_BITS + 1;
    // Output component width
    localparam int OUT_BITS      = 16;

    typedef logic signed [OUT_BITS-1:0] t_comp;

    // Where the tangent came from
    typedef enum logic [1:0] {
        SRC_EDGE  = 2'd0,
        SRC_AXIS  = 2'd1,
        SRC_FIXED = 2'd2
    } t_tan_src;

    typedef struct packed {
        t_comp    normal_x;
        t_comp    normal_y;
        t_comp    normal_z;
        t_comp    tangent_x;
        t_comp    tangent_y;
        t_comp    tangent_z;
        logic     normal_degenerate;
        t_tan_src tangent_source;
    } t_result;

endpackage

`default_nettype wire

>>> sv/tnt_if.sv
`default_nettype none

// Triangle input channel
interface tnt_in_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_a_z;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_b_z;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [COORD_BITS-1:0] vertex_c_z;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_a_z,
               vertex_b_x, vertex_b_y, vertex_b_z,
               vertex_c_x, vertex_c_y, vertex_c_z,
        input  ready
    );
    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_a_z,
               vertex_b_x, vertex_b_y, vertex_b_z,
               vertex_c_x, vertex_c_y, vertex_c_z,
        output ready
    );
endinterface

// Result channel
interface tnt_out_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  normal_x;
    logic signed [15:0]  normal_y;
    logic signed [15:0]  normal_z;
    logic signed [15:0]  tangent_x;
    logic signed [15:0]  tangent_y;
    logic signed [15:0]  tangent_z;
    logic                normal_degenerate;
    logic [1:0]          tangent_source;

    modport source (
        output valid, normal_x, normal_y, normal_z,
               tangent_x, tangent_y, tangent_z,
               normal_degenerate, tangent_source,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z,
               tangent_x, tangent_y, tangent_z,
               normal_degenerate, tangent_source,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/triangle_normal_tangent.sv
// Pipeline: edge and cross-product stages, align/square/sum stages,
//   a square root stage per root bit, a numerator stage, a divider stage
//   per quotient bit and the output register.
// Throughput: one triangle per cycle while the skid register is free; every stage is pipelined.
// Reset: synchronous, active low; clears all valid bits, no other initialization.
`default_nettype none

`include "triangle_normal_tangent_assert.svh"

module triangle_normal_tangent #(
    parameter int COORD_BITS     = 24,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tnt_in_if.sink   i_tri,
    tnt_out_if.source o_res
);

    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * EW;
    localparam int CW = 2 * EW + 1;

    localparam logic [UNIT_FRAC_BITS:0] UNIT_ONE = {1'b1, {UNIT_FRAC_BITS{1'b0}}};
    localparam tnt_pkg::t_comp ONE_OUT = tnt_pkg::t_comp'(UNIT_ONE);

    logic w_en;
    logic r_out_valid;
    logic r_skid_valid;

    // The pipeline moves while the skid register is free
    assign w_en        = !r_skid_valid;
    assign i_tri.ready = w_en;

    // Stage 1: edges b-a and c-a
    logic [2:0][COORD_BITS-1:0] w_a, w_b, w_c;
    logic [2:0][EW-1:0]         r1_e1, r1_e2;
    logic                       r1_valid;

    assign w_a = {i_tri.vertex_a_z, i_tri.vertex_a_y, i_tri.vertex_a_x};
    assign w_b = {i_tri.vertex_b_z, i_tri.vertex_b_y, i_tri.vertex_b_x};
    assign w_c = {i_tri.vertex_c_z, i_tri.vertex_c_y, i_tri.vertex_c_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_tri.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_e1[i] <= {w_b[i][COORD_BITS-1], w_b[i]} - {w_a[i][COORD_BITS-1], w_a[i]};
                r1_e2[i] <= {w_c[i][COORD_BITS-1], w_c[i]} - {w_a[i][COORD_BITS-1], w_a[i]};
            end
        end
    end

    // Stage 2: six partial products of the cross product
    logic [5:0][PW-1:0] r2_p;
    logic [2:0][EW-1:0] r2_e1;
    logic               r2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_p[0] <= $signed(r1_e1[1]) * $signed(r1_e2[2]);
            r2_p[1] <= $signed(r1_e1[2]) * $signed(r1_e2[1]);
            r2_p[2] <= $signed(r1_e1[2]) * $signed(r1_e2[0]);
            r2_p[3] <= $signed(r1_e1[0]) * $signed(r1_e2[2]);
            r2_p[4] <= $signed(r1_e1[0]) * $signed(r1_e2[1]);
            r2_p[5] <= $signed(r1_e1[1]) * $signed(r1_e2[0]);
            r2_e1   <= r1_e1;
        end
    end

    // Stage 3: cross product differences
    logic [2:0][CW-1:0] r3_cross;
    logic [2:0][EW-1:0] r3_e1;
    logic               r3_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_cross[i] <= {r2_p[2*i][PW-1], r2_p[2*i]}
                             - {r2_p[2*i+1][PW-1], r2_p[2*i+1]};
            end
            r3_e1 <= r2_e1;
        end
    end

    // Stage 4: signs, magnitudes, degenerate checks, tangent vector
    logic                w_degen;
    logic [2:0][EW-1:0]  w_tv;
    logic                w_tzero;
    logic [2:0][CW-1:0]  r4_nmag;
    logic [2:0]          r4_nneg;
    logic [2:0][EW-1:0]  r4_tmag;
    logic [2:0]          r4_tneg;
    logic                r4_degen;
    logic                r4_tzero;
    logic                r4_valid;

    assign w_degen = (r3_cross[0] == '0) && (r3_cross[1] == '0) && (r3_cross[2] == '0);

    // Removing the normal part leaves b-a, or clears y for the up-vector fallback
    always_comb begin
        w_tv    = r3_e1;
        if (w_degen) begin
            w_tv[1] = '0;
        end
        w_tzero = (w_tv[0] == '0) && (w_tv[1] == '0) && (w_tv[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_nneg[i] <= r3_cross[i][CW-1];
                r4_nmag[i] <= r3_cross[i][CW-1] ? ('0 - r3_cross[i]) : r3_cross[i];
                r4_tneg[i] <= w_tv[i][EW-1];
                r4_tmag[i] <= w_tv[i][EW-1] ? ('0 - w_tv[i]) : w_tv[i];
            end
            r4_degen <= w_degen;
            r4_tzero <= w_tzero;
        end
    end

    // Normalizers for normal and tangent, equal latency
    logic                              w_nrm_valid, w_tan_valid;
    logic [2:0][tnt_pkg::OUT_BITS-1:0] w_nrm_comp, w_tan_comp;
    logic                              w_nrm_degen, w_tan_zero;

    tnt_unit #(
        .MAG_BITS  (CW),
        .FRAC_BITS (UNIT_FRAC_BITS),
        .TAG_BITS  (1)
    ) u_nrm_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_valid),
        .i_mag   (r4_nmag),
        .i_neg   (r4_nneg),
        .i_tag   (r4_degen),
        .o_valid (w_nrm_valid),
        .o_comp  (w_nrm_comp),
        .o_tag   (w_nrm_degen)
    );

    tnt_unit #(
        .MAG_BITS  (EW),
        .FRAC_BITS (UNIT_FRAC_BITS),
        .TAG_BITS  (1)
    ) u_tan_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_valid),
        .i_mag   (r4_tmag),
        .i_neg   (r4_tneg),
        .i_tag   (r4_tzero),
        .o_valid (w_tan_valid),
        .o_comp  (w_tan_comp),
        .o_tag   (w_tan_zero)
    );

    // Fallbacks. A zero tangent only occurs with the (0,1,0) normal, whose axis
    // cross is always (0,0,1); the fixed (1,0,0) case is unreachable.
    tnt_pkg::t_result n_res;

    always_comb begin
        n_res.normal_x          = w_nrm_degen ? '0      : w_nrm_comp[0];
        n_res.normal_y          = w_nrm_degen ? ONE_OUT : w_nrm_comp[1];
        n_res.normal_z          = w_nrm_degen ? '0      : w_nrm_comp[2];
        n_res.tangent_x         = w_tan_zero  ? '0      : w_tan_comp[0];
        n_res.tangent_y         = w_tan_zero  ? '0      : w_tan_comp[1];
        n_res.tangent_z         = w_tan_zero  ? ONE_OUT : w_tan_comp[2];
        n_res.normal_degenerate = w_nrm_degen;
        n_res.tangent_source    = w_tan_zero ? tnt_pkg::SRC_AXIS : tnt_pkg::SRC_EDGE;
    end

    // Output register plus skid register
    tnt_pkg::t_result r_out;
    tnt_pkg::t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_res.ready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_nrm_valid) begin
            if (!r_out_valid || o_res.ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (o_res.ready) begin
                r_out <= r_skid;
            end
        end else if (w_nrm_valid) begin
            if (!r_out_valid || o_res.ready) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.normal_x          = r_out.normal_x;
    assign o_res.normal_y          = r_out.normal_y;
    assign o_res.normal_z          = r_out.normal_z;
    assign o_res.tangent_x         = r_out.tangent_x;
    assign o_res.tangent_y         = r_out.tangent_y;
    assign o_res.tangent_z         = r_out.tangent_z;
    assign o_res.normal_degenerate = r_out.normal_degenerate;
    assign o_res.tangent_source    = r_out.tangent_source;

    // Checks
    `TNT_ASSERT_IMPL(a_skid_has_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid beat without output beat")
    `TNT_ASSERT_IMPL(a_units_aligned, i_clk, i_rst_n, 1'b1, w_nrm_valid == w_tan_valid,
        "normal and tangent pipes out of step")
    `TNT_ASSERT_IMPL(a_axis_needs_degen, i_clk, i_rst_n,
        r_out_valid && (r_out.tangent_source == tnt_pkg::SRC_AXIS),
        r_out.normal_degenerate, "axis tangent on a regular normal")
    `TNT_ASSERT_NEXT(a_skid_fills, i_clk, i_rst_n,
        w_nrm_valid && r_out_valid && !o_res.ready && !r_skid_valid, r_skid_valid,
        "stalled beat not parked in skid")

endmodule

`default_nettype wire

>>> sv/tnt_unit.sv
`default_nettype none

// Pipelined vector normalizer: align, square, sum, square root, divide.
// The stages advance only on enabled cycles.
module tnt_unit #(
    parameter int MAG_BITS  = 51,
    parameter int FRAC_BITS = 14,
    parameter int TAG_BITS  = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [2:0][MAG_BITS-1:0]          i_mag,
    input  logic [2:0]                        i_neg,
    input  logic [TAG_BITS-1:0]               i_tag,
    output logic                              o_valid,
    output logic [2:0][tnt_pkg::OUT_BITS-1:0] o_comp,
    output logic [TAG_BITS-1:0]               o_tag
);

    localparam int PW    = $clog2(MAG_BITS + 1);
    localparam int AW    = tnt_pkg::ALIGN_BITS;
    localparam int XW    = MAG_BITS + AW;
    localparam int SQW   = 2 * AW;
    localparam int SW    = tnt_pkg::SUM_BITS;
    localparam int RW    = tnt_pkg::ROOT_REM_BITS;
    localparam int STEPS = tnt_pkg::ROOT_STEPS;
    localparam int LW    = tnt_pkg::ROOT_BITS;
    localparam int QB    = FRAC_BITS + 1;
    localparam int NW    = AW + FRAC_BITS + 1;

    typedef struct packed {
        logic [2:0][AW-1:0]  v;
        logic [2:0]          neg;
        logic [TAG_BITS-1:0] tag;
    } t_carry;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] res;
        t_carry        c;
    } t_root;

    typedef struct packed {
        logic [2:0][NW-1:0]  rem;
        logic [2:0][QB-1:0]  q;
        logic [LW-1:0]       len;
        logic [2:0]          neg;
        logic [TAG_BITS-1:0] tag;
    } t_div;

    // Stage A: bit length of the widest magnitude
    logic [MAG_BITS-1:0]       w_any;
    logic [PW-1:0]             n_a_pos;
    logic                      r_a_valid;
    logic [2:0][MAG_BITS-1:0]  r_a_mag;
    logic [2:0]                r_a_neg;
    logic [TAG_BITS-1:0]       r_a_tag;
    logic [PW-1:0]             r_a_pos;

    assign w_any = i_mag[0] | i_mag[1] | i_mag[2];

    always_comb begin
        n_a_pos = '0;
        for (int k = 0; k < MAG_BITS; k++) begin
            if (w_any[k]) begin
                n_a_pos = PW'(k + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag <= i_mag;
            r_a_neg <= i_neg;
            r_a_tag <= i_tag;
            r_a_pos <= n_a_pos;
        end
    end

    // Stage B: common shift, mag * 2^30 / 2^pos truncated
    logic [2:0][XW-1:0] w_b_ext;
    t_carry             n_b;
    t_carry             r_b;
    logic               r_b_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_b_ext[i] = {r_a_mag[i], {AW{1'b0}}} >> r_a_pos;
            n_b.v[i]   = w_b_ext[i][AW-1:0];
        end
        n_b.neg = r_a_neg;
        n_b.tag = r_a_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b <= n_b;
        end
    end

    // Stage C: squares
    logic [2:0][SQW-1:0] n_c_sq;
    logic [2:0][SQW-1:0] r_c_sq;
    t_carry              r_c;
    logic                r_c_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c_sq[i] = r_b.v[i] * r_b.v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_sq <= n_c_sq;
            r_c    <= r_b;
        end
    end

    // Stage D: sum of squares
    logic [SW-1:0] r_d_sum;
    t_carry        r_d;
    logic          r_d_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_sum <= {2'b00, r_c_sq[0]} + {2'b00, r_c_sq[1]} + {2'b00, r_c_sq[2]};
            r_d     <= r_c;
        end
    end

    // Square root, one result bit per stage
    t_root r_rt       [STEPS];
    logic  r_rt_valid [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_root
        localparam logic [RW-1:0] STEP_BIT = RW'(1) << (SW - 2 * k);
        t_root         w_in;
        logic          w_in_valid;
        logic [RW-1:0] w_try;
        t_root         n_rt;

        if (k == 0) begin : g_first
            assign w_in.rem   = {2'b00, r_d_sum};
            assign w_in.res   = '0;
            assign w_in.c     = r_d;
            assign w_in_valid = r_d_valid;
        end else begin : g_next
            assign w_in       = r_rt[k-1];
            assign w_in_valid = r_rt_valid[k-1];
        end

        assign w_try = w_in.res + STEP_BIT;

        always_comb begin
            n_rt = w_in;
            if (w_in.rem >= w_try) begin
                n_rt.rem = w_in.rem - w_try;
                n_rt.res = (w_in.res >> 1) + STEP_BIT;
            end else begin
                n_rt.res = w_in.res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_rt_valid[k] <= w_in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rt[k] <= n_rt;
            end
        end
    end

    // Stage N: rounded numerators v * 2^F + len / 2
    logic [LW-1:0] w_len;
    t_div          n_n;
    t_div          r_n;
    logic          r_n_valid;

    assign w_len = r_rt[STEPS-1].res[LW-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_n.rem[i] = NW'({r_rt[STEPS-1].c.v[i], {FRAC_BITS{1'b0}}}) + NW'(w_len >> 1);
        end
        n_n.q   = '0;
        n_n.len = w_len;
        n_n.neg = r_rt[STEPS-1].c.neg;
        n_n.tag = r_rt[STEPS-1].c.tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (i_en) begin
            r_n_valid <= r_rt_valid[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= n_n;
        end
    end

    // Restoring division, one quotient bit per stage, three lanes
    t_div r_dv       [QB];
    logic r_dv_valid [QB];

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int SH = QB - 1 - j;
        t_div          w_in;
        logic          w_in_valid;
        logic [NW-1:0] w_den;
        t_div          n_dv;

        if (j == 0) begin : g_first
            assign w_in       = r_n;
            assign w_in_valid = r_n_valid;
        end else begin : g_next
            assign w_in       = r_dv[j-1];
            assign w_in_valid = r_dv_valid[j-1];
        end

        assign w_den = NW'(w_in.len) << SH;

        always_comb begin
            n_dv = w_in;
            for (int i = 0; i < 3; i++) begin
                if (w_in.rem[i] >= w_den) begin
                    n_dv.rem[i]    = w_in.rem[i] - w_den;
                    n_dv.q[i][SH]  = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_dv_valid[j] <= w_in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[j] <= n_dv;
            end
        end
    end

    // Apply signs, wrap to the output width
    logic signed [QB:0] w_s [3];

    for (genvar i = 0; i < 3; i++) begin : g_sign
        assign w_s[i]    = r_dv[QB-1].neg[i] ? -$signed({1'b0, r_dv[QB-1].q[i]})
                                             :  $signed({1'b0, r_dv[QB-1].q[i]});
        assign o_comp[i] = tnt_pkg::t_comp'(w_s[i]);
    end

    assign o_valid = r_dv_valid[QB-1];
    assign o_tag   = r_dv[QB-1].tag;

endmodule

`default_nettype wire

>>> sim/triangle_normal_tangent_test.sv
`timescale 1ns / 100ps

module triangle_normal_tangent_test;

    localparam int  N_RANDOM   = 1880;
    localparam int  WD_LIMIT   = 3000;
    localparam int  DRAIN_CYC  = 120;
    localparam int  FRAC       = 14;
    localparam longint ONE     = 64'sd1 <<< FRAC;
    // 0.999 in Q1.14, rounded
    localparam longint AXIS_THRESH = 16368;

    typedef logic signed [23:0] t_coord;

    typedef struct {
        t_coord           v[9];
        bit               has_exp;
        tnt_pkg::t_result exp_res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tnt_in_if #(.COORD_BITS(24)) tri_bus ();
    tnt_out_if                   res_bus ();

    triangle_normal_tangent dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_bus),
        .o_res   (res_bus)
    );

    t_row             directed_rows[$];
    tnt_pkg::t_result frame_q[$];
    int               n_errors;
    int               n_in_beats;
    int               idle_cycles;
    bit               hold_done;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Integer square root, floor
    function automatic longint unsigned isqrt_floor(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Scale a vector to unit length in Q1.14; returns 0 for the zero vector
    function automatic bit unit_dir(input longint v[3], output longint u[3]);
        longint unsigned m[3];
        longint unsigned s[3];
        longint unsigned orv, sum, len, q;
        int p, i;
        orv = 0;
        sum = 0;
        p   = 0;
        for (i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            orv |= m[i];
            u[i] = 0;
        end
        if (orv == 0) return 1'b0;
        while ((orv >> p) != 0) p++;
        for (i = 0; i < 3; i++) begin
            s[i] = (p > 30) ? (m[i] >> (p - 30)) : (m[i] << (30 - p));
            sum += s[i] * s[i];
        end
        len = isqrt_floor(sum);
        if (len == 0) len = 1;
        for (i = 0; i < 3; i++) begin
            q    = ((s[i] << FRAC) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    // Expected normal and tangent of one triangle
    function automatic tnt_pkg::t_result predict_frame(input t_coord tv_in[9]);
        longint            e1[3], e2[3], cr[3], tv[3], n[3], t[3];
        longint            ay;
        bit                degen;
        tnt_pkg::t_tan_src src;
        tnt_pkg::t_result  r;
        int                i;
        for (i = 0; i < 3; i++) begin
            e1[i] = longint'(tv_in[3+i]) - longint'(tv_in[i]);
            e2[i] = longint'(tv_in[6+i]) - longint'(tv_in[i]);
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        degen = (cr[0] == 0) && (cr[1] == 0) && (cr[2] == 0);
        if (degen) begin
            n[0] = 0; n[1] = ONE; n[2] = 0;
        end else begin
            void'(unit_dir(cr, n));
        end
        // Gram-Schmidt leaves the edge alone unless the normal is the fallback
        tv[0] = e1[0];
        tv[1] = degen ? 0 : e1[1];
        tv[2] = e1[2];
        src   = tnt_pkg::SRC_EDGE;
        if (!unit_dir(tv, t)) begin
            ay = (n[1] < 0) ? -n[1] : n[1];
            if (ay < AXIS_THRESH) begin
                tv[0] = n[2]; tv[1] = 0; tv[2] = -n[0];
            end else begin
                tv[0] = 0; tv[1] = -n[2]; tv[2] = n[1];
            end
            if (unit_dir(tv, t)) begin
                src = tnt_pkg::SRC_AXIS;
            end else begin
                t[0] = ONE; t[1] = 0; t[2] = 0;
                src  = tnt_pkg::SRC_FIXED;
            end
        end
        r.normal_x          = tnt_pkg::t_comp'(n[0]);
        r.normal_y          = tnt_pkg::t_comp'(n[1]);
        r.normal_z          = tnt_pkg::t_comp'(n[2]);
        r.tangent_x         = tnt_pkg::t_comp'(t[0]);
        r.tangent_y         = tnt_pkg::t_comp'(t[1]);
        r.tangent_z         = tnt_pkg::t_comp'(t[2]);
        r.normal_degenerate = degen;
        r.tangent_source    = src;
        return r;
    endfunction

    function automatic tnt_pkg::t_result mk_res(input longint nx, ny, nz, tx, ty, tz,
                                                input bit dg,
                                                input tnt_pkg::t_tan_src src);
        tnt_pkg::t_result r;
        r.normal_x  = tnt_pkg::t_comp'(nx);
        r.normal_y  = tnt_pkg::t_comp'(ny);
        r.normal_z  = tnt_pkg::t_comp'(nz);
        r.tangent_x = tnt_pkg::t_comp'(tx);
        r.tangent_y = tnt_pkg::t_comp'(ty);
        r.tangent_z = tnt_pkg::t_comp'(tz);
        r.normal_degenerate = dg;
        r.tangent_source    = src;
        return r;
    endfunction

    task automatic add_row(input longint ax, ay, az, bx, by, bz, cx, cy, cz,
                           input bit has, input tnt_pkg::t_result er);
        t_row row;
        row.v[0] = t_coord'(ax); row.v[1] = t_coord'(ay); row.v[2] = t_coord'(az);
        row.v[3] = t_coord'(bx); row.v[4] = t_coord'(by); row.v[5] = t_coord'(bz);
        row.v[6] = t_coord'(cx); row.v[7] = t_coord'(cy); row.v[8] = t_coord'(cz);
        row.has_exp = has;
        row.exp_res = er;
        directed_rows = {directed_rows, row};
    endtask

    function automatic int idle_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_coord near(input t_coord base, input int span);
        return base + t_coord'($urandom_range(0, 2 * span) - span);
    endfunction

    // Random triangle: mostly well-formed, some flat or collapsed
    task automatic rand_tri(output t_coord v[9]);
        int kind, i, span;
        t_coord ctr;
        kind = $urandom_range(0, 9);
        span = ($urandom_range(0, 1) != 0) ? 300 : 200000;
        for (i = 0; i < 9; i++) v[i] = t_coord'($urandom);
        case (kind)
            0, 1, 2, 3: ;
            4, 5, 6: begin
                for (i = 0; i < 3; i++) begin
                    ctr      = t_coord'($urandom_range(0, 4000000)) - t_coord'(2000000);
                    v[i]     = near(ctr, span);
                    v[3+i]   = near(ctr, span);
                    v[6+i]   = near(ctr, span);
                end
            end
            7: begin
                // collinear: c = a + 2 (b - a)
                for (i = 0; i < 3; i++) begin
                    v[i]   = near(t_coord'(0), 1000000);
                    v[3+i] = near(v[i], span);
                    v[6+i] = v[i] + t_coord'(2) * (v[3+i] - v[i]);
                end
            end
            8: begin
                // two or three points coincide
                for (i = 0; i < 3; i++) v[3+i] = v[i];
                if ($urandom_range(0, 1) != 0) for (i = 0; i < 3; i++) v[6+i] = v[i];
            end
            default: begin
                // edges along the axes, often in a plane
                for (i = 0; i < 9; i++)
                    v[i] = ($urandom_range(0, 2) == 0) ? near(t_coord'(0), span) : t_coord'(0);
            end
        endcase
    endtask

    // Source side
    task automatic send_tri(input t_coord v[9]);
        int g;
        g = idle_len();
        repeat (g) begin
            tri_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        tri_bus.valid      = 1'b1;
        tri_bus.vertex_a_x = v[0]; tri_bus.vertex_a_y = v[1]; tri_bus.vertex_a_z = v[2];
        tri_bus.vertex_b_x = v[3]; tri_bus.vertex_b_y = v[4]; tri_bus.vertex_b_z = v[5];
        tri_bus.vertex_c_x = v[6]; tri_bus.vertex_c_y = v[7]; tri_bus.vertex_c_z = v[8];
        do @(posedge i_clk); while (!tri_bus.ready);
        @(negedge i_clk);
    endtask

    // Sink side: random stalls, one long hold-off to back up the pipeline
    initial begin
        res_bus.ready = 1'b0;
        hold_done     = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_in_beats > 200) begin
                hold_done     = 1'b1;
                res_bus.ready = 1'b0;
                repeat (400) @(negedge i_clk);
            end
            if (n_in_beats % 512 < 128) begin
                res_bus.ready = 1'b1;
            end else begin
                res_bus.ready = 1'b0;
                repeat (idle_len()) @(negedge i_clk);
                res_bus.ready = 1'b1;
            end
        end
    end

    // Record input beats
    always @(posedge i_clk) begin
        if (i_rst_n && tri_bus.valid && tri_bus.ready) begin
            t_coord v[9];
            v[0] = tri_bus.vertex_a_x; v[1] = tri_bus.vertex_a_y; v[2] = tri_bus.vertex_a_z;
            v[3] = tri_bus.vertex_b_x; v[4] = tri_bus.vertex_b_y; v[5] = tri_bus.vertex_b_z;
            v[6] = tri_bus.vertex_c_x; v[7] = tri_bus.vertex_c_y; v[8] = tri_bus.vertex_c_z;
            frame_q = {frame_q, predict_frame(v)};
            n_in_beats++;
        end
    end

    // Check result beats
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            tnt_pkg::t_result got, ex;
            longint           gf[8], ef[8];
            int               i;
            got.normal_x          = res_bus.normal_x;
            got.normal_y          = res_bus.normal_y;
            got.normal_z          = res_bus.normal_z;
            got.tangent_x         = res_bus.tangent_x;
            got.tangent_y         = res_bus.tangent_y;
            got.tangent_z         = res_bus.tangent_z;
            got.normal_degenerate = res_bus.normal_degenerate;
            got.tangent_source    = tnt_pkg::t_tan_src'(res_bus.tangent_source);
            if (frame_q.size() == 0) begin
                $display("%0t: unexpected result beat, normal %0d %0d %0d", $realtime,
                         got.normal_x, got.normal_y, got.normal_z);
                n_errors++;
            end else begin
                ex = frame_q.pop_front();
                gf = '{got.normal_x, got.normal_y, got.normal_z, got.tangent_x,
                       got.tangent_y, got.tangent_z, got.normal_degenerate, got.tangent_source};
                ef = '{ex.normal_x, ex.normal_y, ex.normal_z, ex.tangent_x,
                       ex.tangent_y, ex.tangent_z, ex.normal_degenerate, ex.tangent_source};
                for (i = 0; i < 8; i++) begin
                    if (gf[i] != ef[i]) begin
                        $display("%0t: field %0d expected %0d actual %0d", $realtime, i,
                                 ef[i], gf[i]);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((tri_bus.valid && tri_bus.ready) || (res_bus.valid && res_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("FAIL triangle_normal_tangent");
            $finish;
        end
    end

    // Main sequence
    initial begin
        t_coord           v[9];
        tnt_pkg::t_result ign;
        int               i;
        n_errors    = 0;
        n_in_beats  = 0;
        idle_cycles = 0;
        ign         = '0;
        i_rst_n     = 1'b0;
        tri_bus.valid = 1'b0;
        tri_bus.vertex_a_x = '0; tri_bus.vertex_a_y = '0; tri_bus.vertex_a_z = '0;
        tri_bus.vertex_b_x = '0; tri_bus.vertex_b_y = '0; tri_bus.vertex_b_z = '0;
        tri_bus.vertex_c_x = '0; tri_bus.vertex_c_y = '0; tri_bus.vertex_c_z = '0;

        // all points equal: up normal, tangent from the x-axis cross
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                mk_res(0, ONE, 0, 0, 0, ONE, 1, tnt_pkg::SRC_AXIS));
        // unit right triangle in the xy plane
        add_row(0, 0, 0, 256, 0, 0, 0, 256, 0, 1,
                mk_res(0, 0, ONE, ONE, 0, 0, 0, tnt_pkg::SRC_EDGE));
        // same, wound the other way
        add_row(0, 0, 0, 0, 256, 0, 256, 0, 0, 0, ign);
        // edge along y only, collinear: y part is removed from the tangent
        add_row(0, 0, 0, 0, 256, 0, 0, 512, 0, 1,
                mk_res(0, ONE, 0, 0, 0, ONE, 1, tnt_pkg::SRC_AXIS));
        // collinear along x
        add_row(5, 5, 5, 261, 5, 5, 517, 5, 5, 1,
                mk_res(0, ONE, 0, ONE, 0, 0, 1, tnt_pkg::SRC_EDGE));
        // triangle in the xz plane, normal along -y
        add_row(0, 0, 0, 256, 0, 0, 0, 0, 256, 1,
                mk_res(0, -ONE, 0, ONE, 0, 0, 0, tnt_pkg::SRC_EDGE));
        // extremes of the coordinate range
        add_row(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                8388607, -8388608, 8388607, 0, ign);
        add_row(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                -8388608, 8388607, -8388608, 0, ign);
        add_row(-8388608, 0, 0, 8388607, 0, 0, 0, 8388607, 0, 0, ign);
        add_row(0, -8388608, 8388607, 0, 8388607, -8388608, 8388607, 0, 0, 0, ign);
        add_row(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                -8388608, -8388608, -8388608, 0, ign);
        add_row(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                8388607, 8388607, 8388607, 0, ign);
        // tiny triangles, one LSB apart
        add_row(0, 0, 0, 1, 0, 0, 0, 0, 1, 0, ign);
        add_row(-1, -1, -1, 0, -1, -1, -1, 0, -1, 0, ign);
        add_row(100, 200, 300, 101, 203, 299, 97, 201, 305, 0, ign);
        // tilted so the normal is close to the y axis
        add_row(0, 0, 0, 10000, 1, 0, 0, 0, 10000, 0, ign);
        add_row(0, 0, 0, 10000, 500, 0, 0, 3, -10000, 0, ign);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows; rows with a typed result also check the predictor
        foreach (directed_rows[r]) begin
            if (directed_rows[r].has_exp &&
                predict_frame(directed_rows[r].v) != directed_rows[r].exp_res) begin
                $display("%0t: row %0d expected %h actual %h", $realtime, r,
                         directed_rows[r].exp_res, predict_frame(directed_rows[r].v));
                n_errors++;
            end
            send_tri(directed_rows[r].v);
        end

        for (i = 0; i < N_RANDOM; i++) begin
            rand_tri(v);
            send_tri(v);
        end
        tri_bus.valid = 1'b0;

        wait (frame_q.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS triangle_normal_tangent");
        end else begin
            $display("FAIL triangle_normal_tangent");
        end
        $finish;
    end

endmodule
